FILE: src/pfra_pkg.sv
`timescale 1ns / 1ps

package pfra_pkg;

    // Default size of the frame map.
    localparam int MAX_PAGES_DEF = 256;

    // Field widths of the item interfaces.
    localparam int CMD_W     = 3;
    localparam int COUNT_W   = 9;
    localparam int INDEX_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int USED_W    = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC_KERNEL = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE_KERNEL  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC_USER   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE_USER    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INIT         = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_RUN    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_COUNT = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_FRAME = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;
    localparam logic [CFG_W-1:0]     USABLE_RESET   = 9'd256;
    localparam logic [CFG_W-1:0]     RESERVED_RESET = 9'd0;

    typedef enum logic [1:0] {
        FS_FREE   = 2'd0,
        FS_FIXED  = 2'd1,
        FS_RECENT = 2'd2
    } t_fstate;

    typedef struct packed {
        t_fstate            state;
        logic [COUNT_W-1:0] run_len;
    } t_frame;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COUNT_W-1:0] page_count;
        logic [INDEX_W-1:0] page_index;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  start_frame;
        logic [USED_W-1:0]   used_pages;
    } t_out_item;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FILL,
        S_RELEASE,
        S_REPORT
    } t_state;

endpackage

FILE: src/pfra_map_ram.sv
`timescale 1ns / 1ps

module pfra_map_ram #(
    parameter int DEPTH = pfra_pkg::MAX_PAGES_DEF,
    parameter int AW    = $clog2(pfra_pkg::MAX_PAGES_DEF)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output pfra_pkg::t_frame o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  pfra_pkg::t_frame i_wr_data
);
    import pfra_pkg::*;

    t_frame r_mem [DEPTH];
    t_frame r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/pfra_ctrl.sv
`timescale 1ns / 1ps

module pfra_ctrl #(
    parameter int MAX_PAGES = pfra_pkg::MAX_PAGES_DEF,
    parameter int AW        = $clog2(pfra_pkg::MAX_PAGES_DEF),
    parameter int NW        = $clog2(pfra_pkg::MAX_PAGES_DEF + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  pfra_pkg::t_in_item  i_item,
    output logic                o_ready,
    input  logic [NW-1:0]       i_n,
    input  logic [NW-1:0]       i_rsv,
    output logic                o_res_valid,
    output pfra_pkg::t_out_item o_res,
    input  logic                i_res_take,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  pfra_pkg::t_frame    i_rd_data,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output pfra_pkg::t_frame    o_wr_data
);
    import pfra_pkg::*;

    localparam int IXW = (NW > INDEX_W) ? NW : INDEX_W;
    localparam logic [NW-1:0] LAST_FRAME = NW'(MAX_PAGES - 1);

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [COUNT_W-1:0]  r_target, n_target;
    logic [COUNT_W-1:0]  r_run, n_run;
    logic [NW-1:0]       r_start, n_start;
    logic [NW-1:0]       r_idx, n_idx;
    logic [COUNT_W-1:0]  r_left, n_left;
    logic [USED_W-1:0]   r_used, n_used;
    logic [NW-1:0]       r_rsv, n_rsv;
    logic                r_report, n_report;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [INDEX_W-1:0]  r_first, n_first;

    logic [NW-1:0]       w_idx_inc;
    logic                w_idx_last;
    logic [IXW-1:0]      w_req_x;
    logic [IXW-1:0]      w_n_x;
    logic [USED_W:0]     w_sum;
    logic [USED_W-1:0]   w_used_add;
    logic [USED_W-1:0]   w_used_dec;
    logic [COUNT_W-1:0]  w_run_nx;
    logic [NW-1:0]       w_start;

    // One shared incrementer walks the map; the end test compares against the frame count.
    assign w_idx_inc  = r_idx + NW'(1);
    assign w_idx_last = (w_idx_inc == i_n);
    assign w_req_x    = IXW'(i_item.page_index);
    assign w_n_x      = IXW'(i_n);
    assign w_sum      = {1'b0, r_used} + {1'b0, r_target};
    assign w_used_add = w_sum[USED_W] ? '1 : w_sum[USED_W-1:0];
    assign w_used_dec = (r_used != '0) ? (r_used - USED_W'(1)) : '0;
    assign w_run_nx   = r_run + COUNT_W'(1);
    assign w_start    = (r_run == '0) ? r_idx : r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_idx    <= '0;
            r_rsv    <= '0;
            r_report <= 1'b0;
            r_used   <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rsv    <= n_rsv;
            r_report <= n_report;
            r_used   <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_target <= n_target;
        r_run    <= n_run;
        r_start  <= n_start;
        r_left   <= n_left;
        r_status <= n_status;
        r_first  <= n_first;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_target  = r_target;
        n_run     = r_run;
        n_start   = r_start;
        n_idx     = r_idx;
        n_left    = r_left;
        n_used    = r_used;
        n_rsv     = r_rsv;
        n_report  = r_report;
        n_status  = r_status;
        n_first   = r_first;
        o_rd_en   = 1'b0;
        o_rd_addr = w_idx_inc[AW-1:0];
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx[AW-1:0];
        o_wr_data = '{state: FS_FREE, run_len: '0};

        unique case (r_state)
            S_INIT: begin
                o_wr_en   = 1'b1;
                o_wr_data = '{state: (r_idx < r_rsv) ? FS_FIXED : FS_FREE, run_len: '0};
                n_idx     = w_idx_inc;
                if (r_idx == LAST_FRAME) begin
                    n_state = r_report ? S_REPORT : S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_start) begin
                    n_cmd    = i_item.command;
                    n_status = STAT_DONE;
                    n_first  = '0;
                    n_run    = '0;
                    n_idx    = '0;
                    unique case (i_item.command) inside
                        CMD_ALLOC_KERNEL, CMD_ALLOC_USER: begin
                            n_target = (i_item.command == CMD_ALLOC_USER) ?
                                       COUNT_W'(1) : i_item.page_count;
                            if (i_item.command == CMD_ALLOC_KERNEL &&
                                i_item.page_count == '0) begin
                                n_status = STAT_BAD_COUNT;
                                n_state  = S_REPORT;
                            end else if (i_n == '0) begin
                                n_status = STAT_NO_RUN;
                                n_state  = S_REPORT;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        CMD_FREE_KERNEL, CMD_FREE_USER: begin
                            if (w_req_x >= w_n_x) begin
                                n_status = STAT_BAD_FRAME;
                                n_state  = S_REPORT;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(w_req_x);
                                n_idx     = NW'(w_req_x);
                                n_state   = S_CHECK;
                            end
                        end
                        CMD_INIT: begin
                            n_rsv    = i_rsv;
                            n_used   = USED_W'(i_rsv);
                            n_report = 1'b1;
                            n_state  = S_INIT;
                        end
                        default: begin
                            n_state = S_REPORT;
                        end
                    endcase
                end
            end

            S_CHECK: begin
                // The read data still holds the requested frame.
                if (i_rd_data.state == FS_FREE) begin
                    n_status = STAT_BAD_FRAME;
                    n_state  = S_REPORT;
                end else if (r_cmd == CMD_FREE_USER) begin
                    o_wr_en = 1'b1;
                    n_used  = w_used_dec;
                    n_state = S_REPORT;
                end else if (i_rd_data.run_len == '0) begin
                    n_status = STAT_BAD_FRAME;
                    n_state  = S_REPORT;
                end else begin
                    n_left  = i_rd_data.run_len;
                    n_state = S_RELEASE;
                end
            end

            S_SCAN: begin
                o_rd_en = 1'b1;
                if (i_rd_data.state == FS_FREE && w_run_nx == r_target) begin
                    n_idx   = w_start;
                    n_first = INDEX_W'(w_start);
                    n_left  = r_target;
                    n_state = S_FILL;
                end else if (w_idx_last) begin
                    n_status = STAT_NO_RUN;
                    n_state  = S_REPORT;
                end else begin
                    n_idx   = w_idx_inc;
                    n_start = w_start;
                    n_run   = (i_rd_data.state == FS_FREE) ? w_run_nx : '0;
                end
            end

            S_FILL: begin
                o_wr_en   = 1'b1;
                o_wr_data = '{state: (r_cmd == CMD_ALLOC_USER) ? FS_RECENT : FS_FIXED,
                              run_len: r_target};
                n_idx     = w_idx_inc;
                n_left    = r_left - COUNT_W'(1);
                if (r_left == COUNT_W'(1)) begin
                    n_used  = w_used_add;
                    n_state = S_REPORT;
                end
            end

            S_RELEASE: begin
                o_rd_en = 1'b1;
                o_wr_en = 1'b1;
                if (i_rd_data.state != FS_FREE) begin
                    n_used = w_used_dec;
                end
                n_idx  = w_idx_inc;
                n_left = r_left - COUNT_W'(1);
                if (r_left == COUNT_W'(1) || w_idx_last) begin
                    n_state = S_REPORT;
                end
            end

            S_REPORT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_REPORT);
    assign o_res       = '{status: r_status, start_frame: r_first, used_pages: r_used};

    // A scan leaves as soon as the run reaches the requested length.
    a_run_below_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_run < r_target))
        else $error("scan run counter reached the target without leaving the scan");

    // Outside initialise, no frame at or above the managed count is ever written.
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && r_state != S_INIT) |-> (r_idx < i_n))
        else $error("map write beyond the managed frames");

    // A fill always has frames left to write.
    a_fill_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_left != '0))
        else $error("fill entered with an empty run");

    // A found run never starts at or above the managed count.
    a_first_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_FILL) |=> (r_idx < i_n))
        else $error("allocated run starts outside the map");

endmodule

FILE: src/page_frame_run_allocator_unit.sv
`timescale 1ns / 1ps

// Page-frame run allocator: a first-fit map of physical page frames.
// Input channel: i_in_valid / o_in_stall carry one command item (alloc kernel run, free
// kernel run, alloc user frame, free user frame, initialise). Output channel:
// o_out_valid / i_out_stall return exactly one result item per command: status, first
// allocated frame and the used-frame count after the command.
// The block works on one item at a time; o_in_stall is high from acceptance until the
// result has moved into the output register. A single map memory port pair and one
// shared index incrementer walk the map one frame per cycle: an alloc (kernel or user)
// scans for a free run and then writes it, a kernel free releases the frames of its run,
// a user free rewrites one frame, and initialise sweeps the whole map; a bad count, bad
// index or unknown command goes straight to the result. The result is visible on the
// output once it has moved into the output register. While the receiver stalls, the
// result holds in the output register and the block already takes and works on the
// next item; it only waits before handing over that next result.
// After reset the block sweeps the whole map to free, one frame per cycle, and accepts
// no item meanwhile. Configuration writes are taken at any time, but should only be
// made while the block is idle.
module page_frame_run_allocator_unit #(
    parameter int MAX_PAGES = pfra_pkg::MAX_PAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pfra_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pfra_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [pfra_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfra_pkg::CFG_W-1:0]          i_cfg_data
);
    import pfra_pkg::*;

    // Address width of the map and width of a frame count up to MAX_PAGES.
    localparam int AW = $clog2(MAX_PAGES);
    localparam int NW = $clog2(MAX_PAGES + 1);
    // Width wide enough to compare a register value against the map size.
    localparam int UW = (NW > CFG_W) ? NW : CFG_W;

    logic [CFG_W-1:0] r_usable;
    logic [CFG_W-1:0] r_reserved;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic [UW-1:0]    w_usable_x;
    logic [UW-1:0]    w_reserved_x;
    logic [NW-1:0]    w_n;
    logic [NW-1:0]    w_rsv;
    logic             w_ready;
    logic             w_start;
    logic             w_res_valid;
    t_out_item        w_res;
    logic             w_take;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    t_frame           w_rd_data;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    t_frame           w_wr_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable   <= USABLE_RESET;
            r_reserved <= RESERVED_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_USABLE:   r_usable   <= i_cfg_data;
                CFG_RESERVED: r_reserved <= i_cfg_data;
            endcase
        end
    end

    // The map manages min(usable_pages, MAX_PAGES) frames, and initialise fixes at
    // most that many low frames.
    assign w_usable_x   = UW'(r_usable);
    assign w_reserved_x = UW'(r_reserved);
    assign w_n   = (w_usable_x > UW'(MAX_PAGES)) ? NW'(MAX_PAGES) : NW'(w_usable_x);
    assign w_rsv = (w_reserved_x > UW'(w_n)) ? w_n : NW'(w_reserved_x);

    assign w_start    = i_in_valid && w_ready;
    assign o_in_stall = !w_ready;

    // The output register takes a new result when it is empty or being emptied.
    assign w_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_take) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    pfra_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .AW        (AW),
        .NW        (NW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (i_in_data),
        .o_ready     (w_ready),
        .i_n         (w_n),
        .i_rsv       (w_rsv),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_take),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    pfra_map_ram #(
        .DEPTH (MAX_PAGES),
        .AW    (AW)
    ) u_map (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

endmodule
